// File: rtl/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

  // Fixed field widths
  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned PosW  = 8;
  localparam int unsigned StW   = 2;
  localparam int unsigned OccW  = 7;
  // Index width: covers any clamped position and any count
  localparam int unsigned IdxW  = 7;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_DELETE_AT  = 3'd5
  } pls_op_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } pls_status_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] value;
  } pls_cmd_t;

endpackage

// File: rtl/pls_in_if.sv
`timescale 1ns / 1ps

interface pls_in_if;
  logic                                valid;
  logic                                ready;
  logic [pls_pkg::OpW-1:0]             operation;
  logic signed [pls_pkg::DataW-1:0]    value;
  logic signed [pls_pkg::PosW-1:0]     position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

// File: rtl/pls_out_if.sv
`timescale 1ns / 1ps

interface pls_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pls_pkg::DataW-1:0]  removed_value;
  logic [pls_pkg::StW-1:0]           status;
  logic [pls_pkg::OccW-1:0]          occupancy;

  modport source (output valid, output removed_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input occupancy,
                  output ready);
endinterface

// File: rtl/pls_cell.sv
`timescale 1ns / 1ps

module pls_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                             clk_i,
  input  pls_pkg::pls_cmd_t                cmd_i,
  input  logic signed [pls_pkg::DataW-1:0] left_i,
  input  logic signed [pls_pkg::DataW-1:0] right_i,
  output logic signed [pls_pkg::DataW-1:0] data_o,
  output logic signed [pls_pkg::DataW-1:0] hit_o
);

  localparam logic [pls_pkg::IdxW-1:0] MyIdx = pls_pkg::IdxW'(Idx);

  logic signed [pls_pkg::DataW-1:0] data_q, data_d;
  logic                             at_idx, past_idx;

  assign at_idx   = (cmd_i.idx == MyIdx);
  assign past_idx = (MyIdx > cmd_i.idx);

  // Insert shifts toward the back, delete pulls from the back neighbor
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (past_idx) begin
        data_d = left_i;
      end else if (at_idx) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      if (past_idx || at_idx) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Entry being removed, zero elsewhere so the top can OR all cells
  assign hit_o  = (cmd_i.del && at_idx) ? data_q : '0;

endmodule

// File: rtl/pls_ctrl.sv
`timescale 1ns / 1ps

module pls_ctrl #(
  parameter int unsigned Capacity = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic [pls_pkg::OpW-1:0]          operation_i,
  input  logic signed [pls_pkg::DataW-1:0] value_i,
  input  logic signed [pls_pkg::PosW-1:0]  position_i,
  output pls_pkg::pls_cmd_t                cmd_o,
  output pls_pkg::pls_status_e             status_o,
  output logic [pls_pkg::OccW-1:0]         occupancy_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic [pls_pkg::IdxW-1:0] cnt, cnt_m1, pidx, idx;
  logic                     full, empty, ins, del;
  pls_pkg::pls_status_e     status;

  assign full   = (count_q == CntW'(Capacity));
  assign empty  = (count_q == '0);
  assign cnt    = pls_pkg::IdxW'(count_q);
  assign cnt_m1 = cnt - pls_pkg::IdxW'(1);
  // Negative positions clamp to the front
  assign pidx   = position_i[pls_pkg::PosW-1] ? '0 : position_i[pls_pkg::IdxW-1:0];

  // Decode the request into target index and shift direction
  always_comb begin
    idx    = '0;
    ins    = 1'b0;
    del    = 1'b0;
    status = pls_pkg::ST_OK;
    case (pls_pkg::pls_op_e'(operation_i))
      pls_pkg::OP_PUSH_FRONT: begin
        idx = '0;
        ins = !full;
      end
      pls_pkg::OP_PUSH_BACK: begin
        idx = cnt;
        ins = !full;
      end
      pls_pkg::OP_INSERT_AT: begin
        idx = (pidx > cnt) ? cnt : pidx;
        ins = !full;
      end
      pls_pkg::OP_POP_FRONT: begin
        idx = '0;
        del = !empty;
      end
      pls_pkg::OP_POP_BACK: begin
        idx = cnt_m1;
        del = !empty;
      end
      pls_pkg::OP_DELETE_AT: begin
        idx = (pidx > cnt_m1) ? cnt_m1 : pidx;
        del = !empty;
      end
      default: begin
        idx = '0;
      end
    endcase
    case (pls_pkg::pls_op_e'(operation_i))
      pls_pkg::OP_PUSH_FRONT, pls_pkg::OP_PUSH_BACK, pls_pkg::OP_INSERT_AT: begin
        if (full) status = pls_pkg::ST_FULL;
      end
      pls_pkg::OP_POP_FRONT, pls_pkg::OP_POP_BACK, pls_pkg::OP_DELETE_AT: begin
        if (empty) status = pls_pkg::ST_EMPTY;
      end
      default: begin
        status = pls_pkg::ST_OK;
      end
    endcase
  end

  // Occupancy after this transfer
  always_comb begin
    count_d = count_q;
    if (ins) begin
      count_d = count_q + CntW'(1);
    end else if (del) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  assign cmd_o.ins   = fire_i && ins;
  assign cmd_o.del   = fire_i && del;
  assign cmd_o.idx   = idx;
  assign cmd_o.value = value_i;
  assign status_o    = status;
  assign occupancy_o = pls_pkg::OccW'(count_d);

endmodule

// File: rtl/positional_list_store.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a chain of
// cells, one entry per cell. Push, insert, pop and delete at any position all
// take effect at once: every cell decides locally whether to hold, take its
// front neighbor, take the new value or take its back neighbor, so the whole
// list shifts together. One request is accepted per clock, and each gives
// one registered result (removed value, status, occupancy after the request)
// on the following cycle; a request is taken while that result waits as long
// as the result is being taken in the same cycle. No clearing pass after reset.

module positional_list_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pls_in_if.sink    req_i,
  pls_out_if.source rsp_o
);

  pls_pkg::pls_cmd_t                cmd;
  pls_pkg::pls_status_e             status;
  logic [pls_pkg::OccW-1:0]         occupancy;
  logic                             fire;
  logic signed [pls_pkg::DataW-1:0] cell_data [CAPACITY];
  logic signed [pls_pkg::DataW-1:0] cell_hit  [CAPACITY];
  logic signed [pls_pkg::DataW-1:0] removed;

  logic                             valid_q;
  logic signed [pls_pkg::DataW-1:0] removed_q;
  logic [pls_pkg::StW-1:0]          status_q;
  logic [pls_pkg::OccW-1:0]         occ_q;

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  pls_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .operation_i (req_i.operation),
    .value_i     (req_i.value),
    .position_i  (req_i.position),
    .cmd_o       (cmd),
    .status_o    (status),
    .occupancy_o (occupancy)
  );

  // Cell chain; the ends tie to the new value and to the cell itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pls_pkg::DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pls_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .hit_o   (cell_hit[i])
    );
  end

  // At most one cell reports a hit
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_hit[i];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      removed_q <= removed;
      status_q  <= status;
      occ_q     <= occupancy;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.occupancy     = occ_q;

endmodule
